// ===== design/dnf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnf_pkg
// Shared types and constants of the decimal number formatter.
// ----------------------------------------------------------------------------
package dnf_pkg;

    localparam int MAG_W      = 64;                 // magnitude bits
    localparam int BIT_CNT_W  = $clog2(MAG_W);      // conversion step counter
    localparam int NUM_DIGITS = 20;                 // decimal digits of 2^64-1
    localparam int ND_W       = $clog2(NUM_DIGITS + 1);
    localparam int MAX_WIDTH  = 64;                 // saturated field width
    localparam int CNT_W      = $clog2(MAX_WIDTH + 1);
    localparam int CHAR_W     = 8;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 8;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_LEFT_FILL  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_RIGHT_FILL = 1'b1;

    localparam logic [CHAR_W-1:0] FILL_LEFT_RST  = 8'h20;   // space
    localparam logic [CHAR_W-1:0] FILL_RIGHT_RST = 8'h30;   // '0'
    localparam logic [CHAR_W-1:0] CHAR_ZERO      = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS     = 8'h2D;

    typedef logic [3:0] bcd_t;

    typedef enum logic [1:0] {
        CHAIN_HOLD,
        CHAIN_CLEAR,
        CHAIN_DABBLE,   // add-3 correct, then shift one binary bit in
        CHAIN_SHIFT     // move every digit one place toward the top
    } chain_op_t;

    typedef struct packed {
        chain_op_t op;
        logic      bit_in;
    } chain_ctl_t;

endpackage

// ===== design/decimal_number_formatter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_number_formatter
// Unsigned 64-bit value to padded ASCII decimal text, one char per word.
// ----------------------------------------------------------------------------
// One input word carries a 64-bit magnitude, a minus flag, a signed field
// width, a "no width" flag and a fill override; the block answers with a
// frame of ASCII characters, most significant first, tlast on the final one.
// Positive width right-aligns, negative width left-aligns (|width| saturates
// at 64), the sign counts toward the width. With a '0' fill a right-aligned
// sign leads the padding, otherwise it sits right before the digits. A zero
// magnitude with width 0 gives a single word with tuser set and tdata 0.
// Timing: one word at a time. The binary-to-BCD conversion runs through a
// row of 20 digit cells (one magnitude bit per cycle), then leading zeros
// are dropped, then the characters go out, most significant first; output
// stalls hold them back. s_tready is high only between words; the last
// char may still sit in the output register while the next word is taken.
// ----------------------------------------------------------------------------
module decimal_number_formatter (
    input  logic                                aclk,
    input  logic                                aresetn,
    // config write port
    input  logic                                cfg_wr_en,
    input  logic [dnf_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [dnf_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    // input words
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // magnitude[63:0], negative[64], field_width[72:65], width_unset[73],
    // fill_override[81:74], zeros[87:82]
    input  logic [87:0]                         s_tdata,
    // output words
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [dnf_pkg::CHAR_W-1:0]          m_tdata,   // text_char[7:0]
    output logic                                m_tlast,   // last_char
    output logic [0:0]                          m_tuser    // empty_text[0]
);
    import dnf_pkg::*;

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CONV  = 4'd1;  // double-dabble through the row
    localparam logic [3:0] S_NORM  = 4'd2;  // drop leading zero digits
    localparam logic [3:0] S_PAD_A = 4'd3;  // pad before sign (right, non-'0')
    localparam logic [3:0] S_SIGN  = 4'd4;
    localparam logic [3:0] S_PAD_B = 4'd5;  // pad after sign (right, '0' fill)
    localparam logic [3:0] S_DIG   = 4'd6;
    localparam logic [3:0] S_PAD_C = 4'd7;  // pad after digits (left)
    localparam logic [3:0] S_EMPTY = 4'd8;

    localparam logic [1:0] PAD_POS_A = 2'd0;
    localparam logic [1:0] PAD_POS_B = 2'd1;
    localparam logic [1:0] PAD_POS_C = 2'd2;

    // input fields
    logic [MAG_W-1:0]  in_mag;
    logic              in_neg;
    logic [7:0]        in_width;
    logic              in_unset;
    logic [CHAR_W-1:0] in_ovr;

    assign in_mag   = s_tdata[63:0];
    assign in_neg   = s_tdata[64];
    assign in_width = s_tdata[72:65];
    assign in_unset = s_tdata[73];
    assign in_ovr   = s_tdata[81:74];

    // registers
    logic [3:0]           state_reg,     state_next;
    logic [MAG_W-1:0]     mag_reg,       mag_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg,   bit_cnt_next;
    logic                 neg_reg,       neg_next;
    logic [CHAR_W-1:0]    fill_reg,      fill_next;
    logic [CNT_W-1:0]     absw_reg,      absw_next;
    logic [1:0]           pad_pos_reg,   pad_pos_next;
    logic [ND_W-1:0]      nd_reg,        nd_next;
    logic [CNT_W-1:0]     pad_cnt_reg,   pad_cnt_next;
    logic [CNT_W-1:0]     left_cnt_reg,  left_cnt_next;   // chars still to send
    logic [CHAR_W-1:0]    lfill_reg,     lfill_next;
    logic [CHAR_W-1:0]    rfill_reg,     rfill_next;
    logic                 m_tvalid_reg,  m_tvalid_next;
    logic [CHAR_W-1:0]    m_tdata_reg,   m_tdata_next;
    logic                 m_tlast_reg,   m_tlast_next;
    logic                 m_tuser_reg,   m_tuser_next;

    chain_ctl_t ctl;
    bcd_t       top_digit;

    dnf_digit_chain u_chain (
        .aclk      (aclk),
        .ctl       (ctl),
        .top_digit (top_digit)
    );

    // accept-time decode
    logic              in_acc;
    logic              in_right;
    logic              in_empty;
    logic [CHAR_W-1:0] in_fill;
    logic [7:0]        in_abs8;
    logic [CNT_W-1:0]  in_absw;

    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign in_right = !in_unset && !in_width[7] && (in_width != 8'd0);
    assign in_empty = !in_unset && (in_width == 8'd0) && (in_mag == '0);
    assign in_fill  = (in_ovr != 8'd0) ? in_ovr : (in_right ? rfill_reg : lfill_reg);
    assign in_abs8  = in_width[7] ? (~in_width + 8'd1) : in_width;
    assign in_absw  = in_unset ? '0 :
                      (in_abs8 > 8'(MAX_WIDTH)) ? CNT_W'(MAX_WIDTH) : in_abs8[CNT_W-1:0];

    // length after normalization
    logic [CNT_W-1:0] text_len;
    assign text_len = CNT_W'(nd_reg) + CNT_W'(neg_reg);

    // output slot can take a char this cycle
    logic out_free;
    assign out_free = !m_tvalid_reg || m_tready;

    logic last_now;
    assign last_now = (left_cnt_reg == CNT_W'(1));

    always_comb begin
        state_next    = state_reg;
        mag_next      = mag_reg;
        bit_cnt_next  = bit_cnt_reg;
        neg_next      = neg_reg;
        fill_next     = fill_reg;
        absw_next     = absw_reg;
        pad_pos_next  = pad_pos_reg;
        nd_next       = nd_reg;
        pad_cnt_next  = pad_cnt_reg;
        left_cnt_next = left_cnt_reg;
        lfill_next    = lfill_reg;
        rfill_next    = rfill_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tuser_next  = m_tuser_reg;
        ctl.op        = CHAIN_HOLD;
        ctl.bit_in    = mag_reg[MAG_W-1];

        if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_LEFT_FILL:  lfill_next = cfg_wdata;
                REG_RIGHT_FILL: rfill_next = cfg_wdata;
                default:        lfill_next = lfill_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    if (in_empty) begin
                        state_next = S_EMPTY;
                    end else begin
                        mag_next     = in_mag;
                        neg_next     = in_neg;
                        fill_next    = in_fill;
                        absw_next    = in_absw;
                        bit_cnt_next = BIT_CNT_W'(MAG_W - 1);
                        ctl.op       = CHAIN_CLEAR;
                        if (!in_right)
                            pad_pos_next = PAD_POS_C;
                        else if (in_fill == CHAR_ZERO)
                            pad_pos_next = PAD_POS_B;
                        else
                            pad_pos_next = PAD_POS_A;
                        state_next = S_CONV;
                    end
                end
            end
            S_CONV: begin
                ctl.op   = CHAIN_DABBLE;
                mag_next = {mag_reg[MAG_W-2:0], 1'b0};
                if (bit_cnt_reg == '0) begin
                    nd_next    = ND_W'(NUM_DIGITS);
                    state_next = S_NORM;
                end else begin
                    bit_cnt_next = bit_cnt_reg - 1'b1;
                end
            end
            S_NORM: begin
                if (top_digit == '0 && nd_reg > ND_W'(1)) begin
                    ctl.op  = CHAIN_SHIFT;
                    nd_next = nd_reg - 1'b1;
                end else begin
                    if (absw_reg > text_len) begin
                        pad_cnt_next  = absw_reg - text_len;
                        left_cnt_next = absw_reg;
                    end else begin
                        pad_cnt_next  = '0;
                        left_cnt_next = text_len;
                    end
                    state_next = S_PAD_A;
                end
            end
            S_PAD_A, S_PAD_B, S_PAD_C: begin
                if (pad_cnt_reg != '0 &&
                    ((state_reg == S_PAD_A && pad_pos_reg == PAD_POS_A) ||
                     (state_reg == S_PAD_B && pad_pos_reg == PAD_POS_B) ||
                     (state_reg == S_PAD_C && pad_pos_reg == PAD_POS_C))) begin
                    if (out_free) begin
                        m_tvalid_next = 1'b1;
                        m_tdata_next  = fill_reg;
                        m_tlast_next  = last_now;
                        m_tuser_next  = 1'b0;
                        pad_cnt_next  = pad_cnt_reg - 1'b1;
                        left_cnt_next = left_cnt_reg - 1'b1;
                    end
                end else begin
                    priority if (state_reg == S_PAD_A) state_next = S_SIGN;
                    else if (state_reg == S_PAD_B)     state_next = S_DIG;
                    else                               state_next = S_IDLE;
                end
            end
            S_SIGN: begin
                if (neg_reg) begin
                    if (out_free) begin
                        m_tvalid_next = 1'b1;
                        m_tdata_next  = CHAR_MINUS;
                        m_tlast_next  = last_now;
                        m_tuser_next  = 1'b0;
                        neg_next      = 1'b0;
                        left_cnt_next = left_cnt_reg - 1'b1;
                    end
                end else begin
                    state_next = S_PAD_B;
                end
            end
            S_DIG: begin
                if (nd_reg != '0) begin
                    if (out_free) begin
                        m_tvalid_next = 1'b1;
                        m_tdata_next  = CHAR_ZERO | {4'd0, top_digit};
                        m_tlast_next  = last_now;
                        m_tuser_next  = 1'b0;
                        ctl.op        = CHAIN_SHIFT;
                        nd_next       = nd_reg - 1'b1;
                        left_cnt_next = left_cnt_reg - 1'b1;
                    end
                end else begin
                    state_next = S_PAD_C;
                end
            end
            S_EMPTY: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    m_tlast_next  = 1'b1;
                    m_tuser_next  = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            lfill_reg    <= FILL_LEFT_RST;
            rfill_reg    <= FILL_RIGHT_RST;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            lfill_reg    <= lfill_next;
            rfill_reg    <= rfill_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg      <= mag_next;
        bit_cnt_reg  <= bit_cnt_next;
        neg_reg      <= neg_next;
        fill_reg     <= fill_next;
        absw_reg     <= absw_next;
        pad_pos_reg  <= pad_pos_next;
        nd_reg       <= nd_next;
        pad_cnt_reg  <= pad_cnt_next;
        left_cnt_reg <= left_cnt_next;
        m_tdata_reg  <= m_tdata_next;
        m_tlast_reg  <= m_tlast_next;
        m_tuser_reg  <= m_tuser_next;
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tlast    = m_tlast_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule

// ===== design/dnf_digit_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnf_digit_cell
// One BCD digit of the conversion row: shift-add-3 step or digit move.
// ----------------------------------------------------------------------------
module dnf_digit_cell (
    input  logic              aclk,
    input  dnf_pkg::chain_ctl_t ctl,
    input  logic              carry_in,   // binary bit from lower neighbor
    input  dnf_pkg::bcd_t     digit_in,   // digit from lower neighbor
    output logic              carry_out,
    output dnf_pkg::bcd_t     digit_out
);
    import dnf_pkg::*;

    bcd_t digit_reg;
    bcd_t digit_next;
    bcd_t adj;

    assign adj       = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
    assign carry_out = adj[3];
    assign digit_out = digit_reg;

    always_comb begin
        unique case (ctl.op)
            CHAIN_CLEAR:  digit_next = '0;
            CHAIN_DABBLE: digit_next = {adj[2:0], carry_in};
            CHAIN_SHIFT:  digit_next = digit_in;
            default:      digit_next = digit_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        digit_reg <= digit_next;
    end

endmodule

// ===== design/dnf_digit_chain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnf_digit_chain
// Row of BCD cells, least significant at index 0; top digit exposed.
// ----------------------------------------------------------------------------
module dnf_digit_chain (
    input  logic                aclk,
    input  dnf_pkg::chain_ctl_t ctl,
    output dnf_pkg::bcd_t       top_digit
);
    import dnf_pkg::*;

    logic [NUM_DIGITS-1:0] carry;
    bcd_t                  digit [NUM_DIGITS];

    genvar g;
    generate
        for (g = 0; g < NUM_DIGITS; g++) begin : g_cell
            logic cin;
            bcd_t din;
            if (g == 0) begin : g_low
                assign cin = ctl.bit_in;
                assign din = '0;
            end else begin : g_up
                assign cin = carry[g-1];
                assign din = digit[g-1];
            end
            dnf_digit_cell u_cell (
                .aclk      (aclk),
                .ctl       (ctl),
                .carry_in  (cin),
                .digit_in  (din),
                .carry_out (carry[g]),
                .digit_out (digit[g])
            );
        end
    endgenerate

    assign top_digit = digit[NUM_DIGITS-1];

endmodule

// ===== design/dnf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnf_checker
// Port-level checks of the formatter, bound to the top level.
// ----------------------------------------------------------------------------
module dnf_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic [0:0] m_tuser
);

    // empty text is a one-word frame
    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("empty word without tlast");

    // empty text carries a zero character
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 8'd0)
        else $error("empty word with nonzero data");

    // no new word taken while a frame is still being sent
    a_busy_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input ready in the middle of a frame");

    // stalled output holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output changed while stalled");

endmodule

bind decimal_number_formatter dnf_checker u_dnf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// ===== verif/decimal_number_formatter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_number_formatter_tb
// Self-checking bench for the 64-bit binary to padded decimal text formatter.
// ----------------------------------------------------------------------------
// A short table of hand-picked numbers runs first. It covers the empty text,
// a lone zero, both alignments, sign placement with and without a '0' fill,
// width saturation, a width shorter than the text, and the largest
// magnitude. Random numbers follow in three phases. Each phase has its own
// pair of fill registers, the extremes 0x00 and 0xFF among them, and its own
// mix of sender gaps and receiver stalls. Every character word that comes
// out is checked against a text builder kept in the bench.
// ----------------------------------------------------------------------------
module decimal_number_formatter_tb;

    import dnf_pkg::*;

    localparam int HOLD_CYCLES = 500;    // long receiver hold-off
    localparam int STALL_LIMIT = 4000;   // cycles with no word moving on either side
    localparam int TAIL_CYCLES = 200;    // idle wait before the final report

    // one input word, unpacked
    typedef struct {
        logic [63:0]       mag;
        logic              neg;
        logic signed [7:0] width;
        logic              unset;
        logic [7:0]        ovr;
    } num_req_t;

    // one output word
    typedef struct {
        logic [7:0] ch;
        logic       last;
        logic       empty;
    } text_char_t;

    // hand-picked numbers; txt is the expected text where known is set
    typedef struct {
        logic [63:0] mag;
        bit          neg;
        int          width;
        bit          unset;
        logic [7:0]  ovr;
        string       txt;
        bit          known;
    } num_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [CHAR_W-1:0] m_tdata;
    logic        m_tlast;
    logic [0:0]  m_tuser;

    // bench copy of the fill registers
    logic [7:0] left_fill = FILL_LEFT_RST;
    logic [7:0] right_fill = FILL_RIGHT_RST;

    text_char_t pending_chars[$];   // characters still owed by the block
    int         errors = 0;
    int         chars_checked = 0;
    int         numbers_sent = 0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         hold_kicks = 0;     // bumped by the sender to request a hold-off
    int         hold_done = 0;
    int         hold_left = 0;
    int         quiet_cycles = 0;

    // The table rows assume the reset fills: left ' ', right '0'.
    num_row_t num_rows[] = '{
        '{64'd0,                    1'b0,    0, 1'b0, 8'h00, "",     1'b1}, // empty text
        '{64'd0,                    1'b1,    0, 1'b0, 8'h00, "",     1'b1}, // empty, minus ignored
        '{64'd0,                    1'b0,    0, 1'b1, 8'h00, "0",    1'b1}, // no width: lone zero
        '{64'd0,                    1'b0,    3, 1'b0, 8'h00, "000",  1'b1},
        '{64'd7,                    1'b1,    4, 1'b0, 8'h00, "-007", 1'b1}, // '0' fill: sign leads
        '{64'd7,                    1'b1,    4, 1'b0, 8'h20, "  -7", 1'b1}, // sign next to digits
        '{64'd7,                    1'b1,   -4, 1'b0, 8'h00, "-7  ", 1'b1},
        '{64'd5,                    1'b1,   -3, 1'b0, 8'h30, "-50",  1'b1}, // left, '0' fill
        '{64'd99,                   1'b1,    5, 1'b0, 8'h2A, "**-99", 1'b1},
        '{64'hFFFF_FFFF_FFFF_FFFF,  1'b0,    0, 1'b1, 8'h00,
          "18446744073709551615",   1'b1},
        '{64'hFFFF_FFFF_FFFF_FFFF,  1'b1,    0, 1'b0, 8'h00,
          "-18446744073709551615",  1'b1},
        '{64'd12345,                1'b0,    2, 1'b0, 8'h00, "12345", 1'b1}, // no truncation
        '{64'd123,                  1'b0,   10, 1'b1, 8'h00, "123",  1'b1}, // width ignored
        '{64'd10,                   1'b0,    0, 1'b0, 8'h00, "10",   1'b1},
        '{64'd42,                   1'b0,   64, 1'b0, 8'h00, "",     1'b0},
        '{64'd42,                   1'b1,  -64, 1'b0, 8'h00, "",     1'b0},
        '{64'd9,                    1'b0,  127, 1'b0, 8'h00, "",     1'b0}, // saturates at 64
        '{64'd9,                    1'b1, -128, 1'b0, 8'h00, "",     1'b0},
        '{64'd5,                    1'b0,    5, 1'b0, 8'h01, "",     1'b0},
        '{64'h8000_0000_0000_0000,  1'b1,  -25, 1'b0, 8'hFF, "",     1'b0},
        '{64'd1000000000000000000,  1'b0,   20, 1'b0, 8'h00, "",     1'b0},
        '{64'd9999999999999999999,  1'b1,   22, 1'b0, 8'h5F, "",     1'b0}
    };

    decimal_number_formatter u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always #1 aclk = ~aclk;

    // Append one owed character word to the expected stream.
    function automatic void owe_char(input logic [7:0] ch, input logic last,
                                     input logic empty);
        text_char_t c;
        c.ch    = ch;
        c.last  = last;
        c.empty = empty;
        pending_chars.insert(pending_chars.size(), c);
    endfunction

    // Build the text the block must produce for one number and queue it.
    function automatic void queue_formatted_text(num_req_t r);
        logic [7:0]  txt[$];
        logic [7:0]  digit_chars[$];
        logic [63:0] rest;
        logic [7:0]  fill;
        logic [7:0]  dch;
        logic        right;
        int          w_i;
        int          abs_w;
        int          text_len;
        int          pad;
        w_i = int'(r.width);
        // zero with an explicit zero width prints nothing: one flagged word
        if (!r.unset && w_i == 0 && r.mag == 64'd0) begin
            owe_char(8'h00, 1'b1, 1'b1);
            return;
        end
        right = !r.unset && (w_i > 0);
        fill = right ? right_fill : left_fill;
        if (r.ovr != 8'h00) begin
            fill = r.ovr;
        end
        rest = r.mag;
        do begin
            dch = CHAR_ZERO + 8'(rest % 64'd10);
            digit_chars.push_front(dch);
            rest = rest / 64'd10;
        end while (rest != 64'd0);
        text_len = digit_chars.size() + (r.neg ? 1 : 0);
        abs_w = r.unset ? 0 : (w_i < 0 ? -w_i : w_i);
        if (abs_w > MAX_WIDTH) begin
            abs_w = MAX_WIDTH;
        end
        pad = (abs_w > text_len) ? abs_w - text_len : 0;
        if (right && fill == CHAR_ZERO) begin
            // zero padding goes between the sign and the digits
            if (r.neg) txt = {txt, CHAR_MINUS};
            repeat (pad) txt = {txt, fill};
            txt = {txt, digit_chars};
        end else if (right) begin
            repeat (pad) txt = {txt, fill};
            if (r.neg) txt = {txt, CHAR_MINUS};
            txt = {txt, digit_chars};
        end else begin
            if (r.neg) txt = {txt, CHAR_MINUS};
            txt = {txt, digit_chars};
            repeat (pad) txt = {txt, fill};
        end
        foreach (txt[i]) begin
            owe_char(txt[i], i == txt.size() - 1, 1'b0);
        end
    endfunction

    function automatic num_req_t random_number();
        num_req_t    r;
        logic [63:0] p10;
        r.mag = 64'd0;
        case ($urandom_range(7))
            0: r.mag = 64'd0;
            1: r.mag = 64'($urandom_range(9));
            2: r.mag = {$urandom, $urandom};
            3: r.mag = {$urandom, $urandom} >> $urandom_range(63);
            4: begin
                // digit-count boundaries: 10^k and 10^k - 1
                p10 = 64'd1;
                repeat ($urandom_range(1, 19)) p10 = p10 * 64'd10;
                r.mag = $urandom_range(1) ? p10 : p10 - 64'd1;
            end
            5: r.mag = '1;
            default: r.mag = 64'($urandom);
        endcase
        r.neg = 1'($urandom_range(1));
        // mostly the legal +/-64 range, now and then any 8-bit code
        if ($urandom_range(9) < 8) begin
            r.width = 8'($urandom_range(128) - 64);
        end else begin
            r.width = 8'($urandom_range(255));
        end
        r.unset = ($urandom_range(5) == 0);
        case ($urandom_range(3))
            2: r.ovr = CHAR_ZERO;
            3: r.ovr = 8'($urandom_range(1, 255));
            default: r.ovr = 8'h00;
        endcase
        return r;
    endfunction

    // Offer one number until the block takes it; queue what it must print.
    task automatic send_number(input num_req_t r, input bit known, input string txt);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, r.ovr, r.unset, r.width, r.neg, r.mag};
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        numbers_sent++;
        if (!known) begin
            queue_formatted_text(r);
        end else if (txt.len() == 0) begin
            owe_char(8'h00, 1'b1, 1'b1);
        end else begin
            for (int i = 0; i < txt.len(); i++) begin
                owe_char(8'(txt[i]), i == txt.len() - 1, 1'b0);
            end
        end
    endtask

    // Both fill registers, back to back; only called with nothing in flight.
    task automatic program_fills(input logic [7:0] lf, input logic [7:0] rf);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_LEFT_FILL;
        cfg_wdata <= lf;
        @(posedge aclk);
        cfg_addr  <= REG_RIGHT_FILL;
        cfg_wdata <= rf;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        left_fill  = lf;
        right_fill = rf;
    endtask

    // Receiver: random stalls, or a long hold-off when the sender asks.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (hold_kicks != hold_done) begin
            hold_done <= hold_kicks;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Output checker: every character word against the oldest one owed.
    always @(posedge aclk) begin
        text_char_t exp_c;
        if (aresetn && m_tvalid && m_tready) begin
            chars_checked++;
            if (pending_chars.size() == 0) begin
                errors++;
                $display("%0t: unexpected word: data %02h last %0b empty %0b",
                         $time, m_tdata, m_tlast, m_tuser[0]);
            end else begin
                exp_c = pending_chars.pop_front();
                if (m_tdata !== exp_c.ch || m_tlast !== exp_c.last ||
                    m_tuser[0] !== exp_c.empty) begin
                    errors++;
                    $display("%0t: mismatch: expected data %02h last %0b empty %0b,",
                             $time, exp_c.ch, exp_c.last, exp_c.empty,
                             " got data %02h last %0b empty %0b",
                             m_tdata, m_tlast, m_tuser[0]);
                end
            end
        end
    end

    // Watchdog: nothing moving on either side for too long ends the run.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d chars still owed",
                     $time, STALL_LIMIT, pending_chars.size());
            $display("decimal_number_formatter test failed");
            $finish;
        end
    end

    initial begin : stimulus
        num_req_t r;
        int       n_random;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    // reset fills stay in place for the table
                    send_idle_pct = 28;
                    recv_idle_pct = 60;
                    n_random = 125;
                end
                1: begin
                    send_idle_pct = 60;
                    recv_idle_pct = 28;
                    n_random = 125;
                    program_fills(8'h00, 8'hFF);
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    n_random = 110;
                    program_fills(8'hFF, 8'h00);
                end
            endcase
            if (ph == 0) begin
                foreach (num_rows[i]) begin
                    r.mag   = num_rows[i].mag;
                    r.neg   = num_rows[i].neg;
                    r.width = 8'(num_rows[i].width);
                    r.unset = num_rows[i].unset;
                    r.ovr   = num_rows[i].ovr;
                    send_number(r, num_rows[i].known, num_rows[i].txt);
                end
            end
            for (int i = 0; i < n_random; i++) begin
                // receiver freezes while numbers keep coming, input backs up
                if (ph != 1 && i == n_random / 3) begin
                    hold_kicks++;
                end
                send_number(random_number(), 1'b0, "");
            end
            // sender pauses until the block has printed everything
            s_tvalid <= 1'b0;
            while (pending_chars.size() != 0) @(posedge aclk);
            repeat (20) @(posedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("%0d numbers formatted, %0d character words checked,", numbers_sent,
                 chars_checked);
        $display("over reset, 00/FF and FF/00 fill settings and three stall mixes");
        if (errors == 0 && pending_chars.size() == 0) begin
            $display("decimal_number_formatter test passed");
        end else begin
            $display("%0d mismatches, %0d chars never arrived", errors,
                     pending_chars.size());
            $display("decimal_number_formatter test failed");
        end
        $finish;
    end

endmodule
